@@ rtl/core/wma_pkg.sv @@
package wma_pkg;

  localparam int unsigned WINDOW    = 6;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned WEIGHT_W  = 8;
  localparam int unsigned WSUM_W    = 11;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  localparam weight_t WEIGHT_RESET [WINDOW] = '{
    weight_t'(1), weight_t'(2), weight_t'(3),
    weight_t'(4), weight_t'(5), weight_t'(6)
  };

  localparam slot_t LAST_SLOT = slot_t'(WINDOW - 1);

  function automatic slot_t next_slot(input slot_t s);
    slot_t n;
    n = (s == LAST_SLOT) ? '0 : slot_t'(s + slot_t'(1));
    return n;
  endfunction

endpackage

@@ rtl/core/wma_div.sv @@
module wma_div #(
  parameter int unsigned DVD_W = 23
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DVD_W-1:0]           dividend_i,
  input  logic [wma_pkg::WSUM_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [DVD_W-1:0]           quotient_o
);
  import wma_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [WSUM_W-1:0] rem_q, rem_d;
  logic [WSUM_W-1:0] dvs_q, dvs_d;
  logic [WSUM_W:0]   trial;
  logic [WSUM_W:0]   diff;
  logic              ge;
  logic              last;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign last  = (cnt_q == CNT_W'(DVD_W - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

@@ rtl/core/weighted_moving_average_top.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    adc_value_i
// output    out        out_valid_o / out_stall_i  filtered_value_o, zero_weights_o
// config    in         cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// A priming word only fills the ring; any other word passes through the
// accepting cycle, six multiply-accumulate steps, one check, SAMPLE_BITS + 11
// divider steps and then the result register into the output register; zero
// weights skip the divider. Reset clears the window, the ring pointers and
// the output valid, and loads the default weights. The input is stalled while
// a word is at work and while a finished result cannot enter the output register.
module weighted_moving_average_top #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [SAMPLE_BITS-1:0]        adc_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [SAMPLE_BITS-1:0]        filtered_value_o,
  output logic                          zero_weights_o,
  input  logic                          cfg_we_i,
  input  logic [wma_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wma_pkg::WEIGHT_W-1:0]  cfg_wdata_i
);
  import wma_pkg::*;

  localparam int unsigned ACC_W  = SAMPLE_BITS + WEIGHT_W + 3;
  localparam int unsigned PROD_W = SAMPLE_BITS + WEIGHT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]             state_q, state_d;
  weight_t                weight_q [WINDOW];
  logic [SAMPLE_BITS-1:0] window_q [WINDOW];
  slot_t                  wr_slot_q, wr_slot_d;
  slot_t                  fill_q, fill_d;
  slot_t                  rd_slot_q, rd_slot_d;
  slot_t                  step_q, step_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [WSUM_W-1:0]      wsum_q, wsum_d;
  logic [SAMPLE_BITS-1:0] res_q, res_d;
  logic                   zero_q, zero_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_value_q;
  logic                   out_zero_q;
  logic                   in_acc;
  logic                   out_load;
  logic                   div_start;
  logic                   div_done;
  logic [ACC_W-1:0]       quotient;
  weight_t                w_sel;
  logic [SAMPLE_BITS-1:0] s_sel;
  logic [PROD_W-1:0]      product;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign w_sel    = weight_q[step_q];
  assign s_sel    = window_q[rd_slot_q];
  assign product  = PROD_W'(w_sel) * PROD_W'(s_sel);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    wr_slot_d = wr_slot_q;
    fill_d    = fill_q;
    rd_slot_d = rd_slot_q;
    step_d    = step_q;
    acc_d     = acc_q;
    wsum_d    = wsum_q;
    res_d     = res_q;
    zero_d    = zero_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          wr_slot_d = next_slot(wr_slot_q);
          if (fill_q != LAST_SLOT) begin
            fill_d = fill_q + slot_t'(1);
          end else begin
            rd_slot_d = next_slot(wr_slot_q);
            step_d    = '0;
            acc_d     = '0;
            wsum_d    = '0;
            state_d   = S_MAC;
          end
        end
      end
      S_MAC: begin
        acc_d     = acc_q + ACC_W'(product);
        wsum_d    = wsum_q + WSUM_W'(w_sel);
        rd_slot_d = next_slot(rd_slot_q);
        step_d    = step_q + slot_t'(1);
        if (step_q == LAST_SLOT) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (wsum_q == '0) begin
          res_d   = '0;
          zero_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          zero_d    = 1'b0;
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = quotient[SAMPLE_BITS-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  wma_div #(
    .DVD_W(ACC_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (wsum_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_slot_q   <= '0;
      fill_q      <= '0;
      rd_slot_q   <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        weight_q[i] <= WEIGHT_RESET[i];
        window_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      wr_slot_q   <= wr_slot_d;
      fill_q      <= fill_d;
      rd_slot_q   <= rd_slot_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_index_i <= LAST_SLOT)) begin
        weight_q[cfg_index_i] <= cfg_wdata_i;
      end
      if (in_acc) begin
        window_q[wr_slot_q] <= adc_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    wsum_q <= wsum_d;
    res_q  <= res_d;
    zero_q <= zero_d;
    if (out_load) begin
      out_value_q <= res_q;
      out_zero_q  <= zero_q;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_value_q;
  assign zero_weights_o   = out_zero_q;

endmodule

@@ tb/wma_average_checker.sv @@
module wma_average_checker #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [SAMPLE_BITS-1:0]        adc_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [SAMPLE_BITS-1:0]        filtered_value_i,
  input  logic                          zero_weights_i,
  input  logic                          cfg_we_i,
  input  logic [wma_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wma_pkg::WEIGHT_W-1:0]  cfg_wdata_i,
  output int unsigned                   error_count_o,
  output int unsigned                   pending_o
);
  import wma_pkg::*;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t average;
    logic    zero_weights;
  } average_t;

  average_t             expected_averages [$];
  sample_t              window_q [WINDOW];
  weight_t              weight_q [WINDOW];
  slot_t                write_slot_q;
  logic [SLOT_W-1:0]    fill_count_q;
  int unsigned          errors;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
    error_count_o = errors;
  endtask

  function automatic slot_t step_slot(input slot_t s);
    if (s == slot_t'(WINDOW - 1)) begin
      return '0;
    end
    return slot_t'(s + 1'b1);
  endfunction

  // Stores one word in the ring and, once the ring is primed, queues the
  // weighted average of the window from oldest to newest.
  task automatic take_sample(input sample_t value);
    int unsigned weighted_sum;
    int unsigned weight_sum;
    slot_t       slot;
    average_t    avg;
    window_q[write_slot_q] = value;
    write_slot_q = step_slot(write_slot_q);
    if (fill_count_q < SLOT_W'(WINDOW - 1)) begin
      fill_count_q = fill_count_q + 1'b1;
      return;
    end
    weighted_sum = 0;
    weight_sum = 0;
    slot = write_slot_q;
    for (int i = 0; i < WINDOW; i++) begin
      weighted_sum = weighted_sum + weight_q[i] * window_q[slot];
      weight_sum = weight_sum + weight_q[i];
      slot = step_slot(slot);
    end
    if (weight_sum == 0) begin
      avg.average = '0;
      avg.zero_weights = 1'b1;
    end else begin
      avg.average = sample_t'(weighted_sum / weight_sum);
      avg.zero_weights = 1'b0;
    end
    expected_averages.push_back(avg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    average_t exp;
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        window_q[i] = '0;
        weight_q[i] = WEIGHT_RESET[i];
      end
      write_slot_q = '0;
      fill_count_q = '0;
      expected_averages.delete();
    end else begin
      if (cfg_we_i && cfg_index_i < CFG_IDX_W'(WINDOW)) begin
        weight_q[cfg_index_i] = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_averages.size() == 0) begin
          report($sformatf("result %0d with no word pending", filtered_value_i));
        end else begin
          exp = expected_averages.pop_front();
          if (filtered_value_i !== exp.average) begin
            report($sformatf("filtered_value got %0d, expected %0d",
                             filtered_value_i, exp.average));
          end
          if (zero_weights_i !== exp.zero_weights) begin
            report($sformatf("zero_weights got %b, expected %b",
                             zero_weights_i, exp.zero_weights));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_sample(adc_value_i);
      end
    end
    pending_o = expected_averages.size();
  end

endmodule

@@ tb/tb.sv @@
module tb;
  import wma_pkg::*;

  localparam int unsigned SAMPLE_BITS        = 12;
  localparam int unsigned SETTLE_CYCLES      = SAMPLE_BITS + 30;
  localparam int unsigned IDLE_LIMIT         = 4000;
  localparam int unsigned FIRST_UNUSED_INDEX = WINDOW;
  localparam int unsigned RANDOM_PHASES      = 7;
  localparam int unsigned DIRECTED_COUNT     = 23;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t DIRECTED_SAMPLES [DIRECTED_COUNT] = '{
    12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000,
    12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
    12'hAAA, 12'h555, 12'h001, 12'h800, 12'h7FF, 12'hFFE,
    12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  sample_t              adc_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  sample_t              filtered_value_o;
  logic                 zero_weights_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  weight_t              cfg_wdata_i = '0;

  int unsigned error_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  int unsigned gap_odds = 0;
  bit          no_idling = 1'b0;
  weight_t     next_weights [WINDOW];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  weighted_moving_average_top #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .adc_value_i     (adc_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filtered_value_o(filtered_value_o),
    .zero_weights_o  (zero_weights_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  wma_average_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) average_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .adc_value_i     (adc_value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filtered_value_i(filtered_value_o),
    .zero_weights_i  (zero_weights_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver alternates stall bursts with calm stretches, some of them long.
  initial begin : receiver_stalls
    int unsigned left;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (no_idling) begin
        out_stall_i <= 1'b0;
      end else if (left != 0) begin
        left--;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        left = $urandom_range(0, 1) ? $urandom_range(0, 30) : $urandom_range(100, 400);
      end else begin
        out_stall_i <= 1'b1;
        left = $urandom_range(0, 18);
      end
    end
  end

  function automatic sample_t random_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? {SAMPLE_BITS{1'b1}} : {SAMPLE_BITS{1'b0}};
      1: return sample_t'($urandom_range(0, 15));
      2: return sample_t'((1 << SAMPLE_BITS) - 1 - $urandom_range(0, 15));
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic weight_t random_weight();
    case ($urandom_range(0, 7))
      0, 1: return '0;
      2: return {WEIGHT_W{1'b1}};
      default: return weight_t'($urandom());
    endcase
  endfunction

  task automatic send_sample(input sample_t value);
    if (!no_idling && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_value_i <= value;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_weights();
    for (int i = 0; i < WINDOW; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_wdata_i <= next_weights[i];
      @(posedge clk_i);
    end
    if ($urandom_range(0, 1)) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(FIRST_UNUSED_INDEX + $urandom_range(0, 1));
      cfg_wdata_i <= weight_t'($urandom());
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned words);
    drain();
    program_weights();
    repeat (words) send_sample(random_sample());
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_sample(DIRECTED_SAMPLES[i]);
    end

    gap_odds = 4;
    for (int i = 0; i < WINDOW; i++) next_weights[i] = {WEIGHT_W{1'b1}};
    run_phase(150);

    for (int i = 0; i < WINDOW; i++) next_weights[i] = '0;
    run_phase(60);

    next_weights[0] = weight_t'(1);
    run_phase(60);

    next_weights[0] = '0;
    next_weights[WINDOW-1] = {WEIGHT_W{1'b1}};
    run_phase(60);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gap_odds = $urandom_range(0, 6);
      for (int i = 0; i < WINDOW; i++) next_weights[i] = random_weight();
      run_phase(150);
    end

    no_idling = 1'b1;
    for (int i = 0; i < WINDOW; i++) next_weights[i] = random_weight();
    run_phase(200);

    drain();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/wma_pkg.sv
rtl/core/wma_div.sv
rtl/core/weighted_moving_average_top.sv
tb/wma_average_checker.sv
tb/tb.sv
